@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define AST_CLK_MSG(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
`else
`define AST_CLK(name, clk, rst, prop)
`define AST_CLK_MSG(name, clk, rst, prop, msg)
`endif
`endif

@@ rtl/pidpmd_pkg.sv @@
// Types, constants and the control program of the PID position motor drive.
`default_nettype none
package pidpmd_pkg;

  localparam int PC_W  = 4;
  localparam int ACC_W = 56;

  // Product saturation for ki * I and the clamp of the inner sum.
  localparam logic [52:0]             KI_SAT     = 53'd1 << 52;
  localparam logic signed [ACC_W-1:0] INNER_SAT  = 56'sd70368744177664;
  localparam logic signed [ACC_W-1:0] INNER_NSAT = -56'sd70368744177664;
  localparam logic [46:0]             INNER_MAG  = 47'd1 << 46;

  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_KP       = 3'd1,
    REG_KI       = 3'd2,
    REG_KD       = 3'd3,
    REG_BAND     = 3'd4,
    REG_SETTLE   = 3'd5,
    REG_WINDUP   = 3'd6,
    REG_DUTY_CAP = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,
    OP_CHECK,
    OP_ABS,
    OP_LOAD,
    OP_KI_SUM,
    OP_KI_SIGN,
    OP_KD_LO,
    OP_KD_HI,
    OP_CLAMP,
    OP_SCALE,
    OP_DRIVE,
    OP_BRAKE
  } op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ILO,
    MUL_IHI,
    MUL_DLO,
    MUL_NLO,
    MUL_NHI
  } mul_t;

  typedef struct packed {
    op_t             op;
    mul_t            mul;
    logic            jump_stop;
    logic [PC_W-1:0] target;
    logic            last;
  } ucw_t;

  localparam logic [PC_W-1:0] PC_BRAKE = 4'd14;

  // Control program: one word per step.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{op: OP_NOP, mul: MUL_NONE, jump_stop: 1'b0, target: '0, last: 1'b0};
    unique case (pc)
      4'd0:  w.op = OP_START;
      4'd1:  begin
        w.op        = OP_CHECK;
        w.jump_stop = 1'b1;
        w.target    = PC_BRAKE;
      end
      4'd2:  w.op = OP_ABS;
      4'd3:  w.mul = MUL_ILO;
      4'd4:  begin
        w.op  = OP_LOAD;
        w.mul = MUL_IHI;
      end
      4'd5:  begin
        w.op  = OP_KI_SUM;
        w.mul = MUL_DLO;
      end
      4'd6:  w.op = OP_KI_SIGN;
      4'd7:  w.op = OP_KD_LO;
      4'd8:  w.op = OP_KD_HI;
      4'd9:  w.op = OP_CLAMP;
      4'd10: w.mul = MUL_NLO;
      4'd11: begin
        w.op  = OP_LOAD;
        w.mul = MUL_NHI;
      end
      4'd12: w.op = OP_SCALE;
      4'd13: begin
        w.op   = OP_DRIVE;
        w.last = 1'b1;
      end
      4'd14: begin
        w.op   = OP_BRAKE;
        w.last = 1'b1;
      end
      default: begin
        w.op   = OP_BRAKE;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pid_position_motor_drive.sv @@
// PID position motor drive: microcoded controller with one shared multiplier.
//
// Usage. Each control tick arrives as one slave transaction: s_tuser is the
// command (0 continues, 1 starts a new move and clears the controller state)
// and s_tdata carries the measured encoder position and the emergency input.
// Every tick gives exactly one master transaction with the bridge lines, the
// PWM duty and the arrived and emergency-stopped flags.
// Steps. A tick that computes a drive runs 14 steps of the control program;
// a tick that brakes (arrival, emergency, or no move armed) jumps to the
// brake step after the check step. A new tick is taken only once the program
// of the last one has finished. The single 32x16 multiplier is used five
// times per drive tick.
// Stalls. A finished result sits in the output register; s_tready is high as
// soon as the program has finished, even while that result waits. If the
// next result is ready before the master side takes the old one, the last
// step holds until m_tready frees the register.
// Reset. rst is synchronous and active high; it loads the register defaults,
// clears the controller state, disarms the move and empties the output.
// The user must write configuration through cfg_we, cfg_addr and cfg_wdata only
// while no tick is in flight; the block itself does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module pid_position_motor_drive
  import pidpmd_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = 48,
  parameter int DRIVE_LIMIT    = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave stream: one control tick per transaction.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [30:0] measured_position, [31] emergency
  input  wire logic        s_tuser,   // [0] command
  // Master stream: one result per tick.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] bridge_a, [1] bridge_b, [9:2] duty, [10] arrived,
  // [11] emergency_stopped, [15:12] zero
  output logic [15:0]      m_tdata,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [30:0] cfg_wdata
);

  localparam int IW = INTEGRAL_WIDTH;
  // Signed width that holds +-DRIVE_LIMIT.
  localparam int DW = $clog2(DRIVE_LIMIT + 1) + 1;
  localparam logic signed [DW-1:0] LIM_S = DW'(DRIVE_LIMIT);
  localparam logic signed [IW-1:0] IMAX  = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN  = {1'b1, {(IW-1){1'b0}}};

  // Configuration registers.
  logic signed [30:0] target_position;
  logic [15:0]        prop_gain;
  logic [15:0]        integral_gain;
  logic [15:0]        deriv_gain;
  logic [15:0]        position_band;
  logic [7:0]         settle_drive;
  logic [15:0]        windup_error;
  logic [7:0]         duty_cap;

  // Controller state kept between ticks.
  logic signed [31:0]    previous_error;
  logic signed [IW-1:0]  integral_sum;
  logic signed [DW-1:0]  last_drive;
  logic                  moving;

  // Sequencer.
  logic            busy;
  logic [PC_W-1:0] pc;
  ucw_t            cw;
  logic            advance;

  // Latched tick.
  logic               in_cmd;
  logic signed [30:0] in_pos;
  logic               in_emer;

  // Datapath registers.
  logic signed [31:0]      err;
  logic [31:0]             err_mag;
  logic signed [32:0]      diff;
  logic [32:0]             dmag;
  logic                    dsign;
  logic [IW-1:0]           imag;
  logic                    isign;
  logic [47:0]             prod;
  logic signed [ACC_W-1:0] acc;
  logic [46:0]             inner_mag;
  logic                    inner_neg;
  logic [47:0]             umag;
  logic                    arr_flag;
  logic                    emg_flag;

  // Output register.
  logic       out_valid;
  logic       out_a;
  logic       out_b;
  logic [7:0] out_duty;
  logic       out_arr;
  logic       out_emg;

  // Combinational helpers.
  logic [31:0]             mul_a;
  logic [15:0]             mul_b;
  logic [47:0]             mul_p;
  logic [31:0]             cur_err_mag;
  logic                    ld_ok;
  logic                    stop_arr;
  logic                    stop_emg;
  logic                    stop_now;
  logic signed [IW:0]      isum;
  logic signed [IW-1:0]    isat;
  logic [52:0]             ksum;
  logic [52:0]             kclamp;
  logic signed [ACC_W-1:0] acc_signed;
  logic signed [ACC_W-1:0] err_q8;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] kd_hi;
  logic [63:0]             scale_sum;
  logic [DW-2:0]           umin;
  logic                    u_neg;

  assign cw       = ucode(pc);
  assign advance  = busy && !(cw.last && out_valid && !m_tready);
  assign s_tready = !busy;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_emg, out_arr, out_duty, out_b, out_a};

  // The shared multiplier; its operands come from registers only.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul)
      MUL_ILO: begin
        mul_a = imag[31:0];
        mul_b = integral_gain;
      end
      MUL_IHI: begin
        mul_a = 32'(imag[IW-1:32]);
        mul_b = integral_gain;
      end
      MUL_DLO: begin
        mul_a = dmag[31:0];
        mul_b = deriv_gain;
      end
      MUL_NLO: begin
        mul_a = inner_mag[31:0];
        mul_b = prop_gain;
      end
      MUL_NHI: begin
        mul_a = 32'(inner_mag[46:32]);
        mul_b = prop_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 48'(mul_a) * 48'(mul_b);

  // Stop decision of the check step. Arrival wins over emergency, and a
  // negative last drive always passes the settle test.
  assign cur_err_mag = err[31] ? 32'(-err) : 32'(err);
  assign ld_ok    = last_drive[DW-1] ||
                    (16'(last_drive[DW-2:0]) <= 16'(settle_drive));
  assign stop_arr = moving && (cur_err_mag <= 32'(position_band)) && ld_ok;
  assign stop_emg = moving && !stop_arr && in_emer;
  assign stop_now = !moving || stop_arr || stop_emg;

  // Integral update, saturating at the integral width.
  assign isum = {integral_sum[IW-1], integral_sum} + {{(IW+1-32){err[31]}}, err};
  assign isat = (isum[IW] != isum[IW-1]) ? (isum[IW] ? IMIN : IMAX) : isum[IW-1:0];

  // ki * |I| from two partial products, saturated at 2^52.
  assign ksum   = {5'b0, acc[47:0]} + {1'b0, prod[19:0], 32'b0};
  assign kclamp = ((|prod[47:20]) || (ksum > KI_SAT)) ? KI_SAT : ksum;

  assign acc_signed = isign ? -acc : acc;
  assign err_q8     = {{(ACC_W-32){err[31]}}, err} <<< 8;
  assign prod_ext   = {8'b0, prod};
  assign kd_hi      = {8'b0, deriv_gain, 32'b0};

  // kp * |inner| from two partial products, scaled by 2^-16.
  assign scale_sum = {16'b0, acc[47:0]} + {prod[31:0], 32'b0};

  // Final drive: clamp and direction.
  assign umin  = (umag > 48'(DRIVE_LIMIT)) ? (DW-1)'(DRIVE_LIMIT) : umag[DW-2:0];
  assign u_neg = inner_neg && (umag != '0);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      prop_gain       <= 16'd256;
      integral_gain   <= '0;
      deriv_gain      <= '0;
      position_band   <= 16'd50;
      settle_drive    <= 8'd55;
      windup_error    <= 16'd200;
      duty_cap        <= 8'd200;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TARGET:   target_position <= cfg_wdata;
        REG_KP:       prop_gain       <= cfg_wdata[15:0];
        REG_KI:       integral_gain   <= cfg_wdata[15:0];
        REG_KD:       deriv_gain      <= cfg_wdata[15:0];
        REG_BAND:     position_band   <= cfg_wdata[15:0];
        REG_SETTLE:   settle_drive    <= cfg_wdata[7:0];
        REG_WINDUP:   windup_error    <= cfg_wdata[15:0];
        REG_DUTY_CAP: duty_cap        <= cfg_wdata[7:0];
        default:      ;
      endcase
    end
  end

  // Sequencer and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
        pc   <= '0;
      end else if (advance) begin
        if (cw.last) begin
          busy <= 1'b0;
        end else if (cw.jump_stop && stop_now) begin
          pc <= cw.target;
        end else begin
          pc <= pc + 1'b1;
        end
      end
      if (advance && cw.last) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
      last_drive     <= '0;
      moving         <= 1'b0;
    end else if (advance) begin
      case (cw.op)
        OP_START: begin
          if (in_cmd) begin
            previous_error <= '0;
            integral_sum   <= '0;
            last_drive     <= '0;
            moving         <= 1'b1;
          end
        end
        OP_CHECK: begin
          if (stop_now) begin
            moving <= 1'b0;
          end else begin
            integral_sum <= isat;
          end
        end
        OP_DRIVE: begin
          if ((umag > 48'(DRIVE_LIMIT)) && (err_mag > 32'(windup_error))) begin
            integral_sum <= '0;
          end
          previous_error <= err;
          last_drive     <= u_neg ? -$signed({1'b0, umin}) : $signed({1'b0, umin});
        end
        default: ;
      endcase
    end
  end

  // Input latch and datapath registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_pos  <= s_tdata[30:0];
      in_emer <= s_tdata[31];
    end
    if (advance) begin
      if (cw.mul != MUL_NONE) begin
        prod <= mul_p;
      end
      case (cw.op)
        OP_START: begin
          err <= {target_position[30], target_position} - {in_pos[30], in_pos};
        end
        OP_CHECK: begin
          arr_flag <= stop_arr;
          emg_flag <= stop_emg;
          err_mag  <= cur_err_mag;
          diff     <= {err[31], err} - {previous_error[31], previous_error};
        end
        OP_ABS: begin
          imag  <= integral_sum[IW-1] ? (~integral_sum + 1'b1) : integral_sum;
          isign <= integral_sum[IW-1];
          dmag  <= diff[32] ? 33'(-diff) : 33'(diff);
          dsign <= diff[32];
        end
        OP_LOAD:    acc <= prod_ext;
        OP_KI_SUM:  acc <= {3'b0, kclamp};
        OP_KI_SIGN: acc <= acc_signed + err_q8;
        OP_KD_LO:   acc <= dsign ? acc - prod_ext : acc + prod_ext;
        OP_KD_HI: begin
          if (dmag[32]) begin
            acc <= dsign ? acc - kd_hi : acc + kd_hi;
          end
        end
        OP_CLAMP: begin
          if (acc > INNER_SAT) begin
            inner_mag <= INNER_MAG;
            inner_neg <= 1'b0;
          end else if (acc < INNER_NSAT) begin
            inner_mag <= INNER_MAG;
            inner_neg <= 1'b1;
          end else begin
            inner_mag <= acc[ACC_W-1] ? 47'(-acc) : 47'(acc);
            inner_neg <= acc[ACC_W-1];
          end
        end
        OP_SCALE: umag <= scale_sum[63:16];
        OP_DRIVE: begin
          out_a    <= u_neg;
          out_b    <= !u_neg;
          out_duty <= (16'(umin) > 16'(duty_cap)) ? duty_cap : 8'(umin);
          out_arr  <= 1'b0;
          out_emg  <= 1'b0;
        end
        OP_BRAKE: begin
          out_a    <= 1'b0;
          out_b    <= 1'b0;
          out_duty <= 8'd255;
          out_arr  <= arr_flag;
          out_emg  <= emg_flag;
        end
        default: ;
      endcase
    end
  end

  // Checks on the control program and the result encoding.
  `AST_CLK_MSG(a_pc_range, clk, rst, busy |-> pc <= PC_BRAKE, "program counter out of range")
  `AST_CLK(a_brake_form, clk, rst, out_valid && (out_arr || out_emg) |-> out_duty == 8'd255 && !out_a && !out_b)
  `AST_CLK(a_one_reason, clk, rst, out_valid |-> !(out_arr && out_emg))
  `AST_CLK_MSG(a_stop_at_check, clk, rst, $fell(moving) && !$past(rst) |-> $past(cw.op == OP_CHECK), "move ended outside the check step")
  `AST_CLK(a_drive_limit, clk, rst, last_drive <= LIM_S && last_drive >= -LIM_S)

endmodule
`default_nettype wire
